>>> src/sfm5_pkg.sv
`timescale 1ns / 1ps

package sfm5_pkg;

  localparam int SampleW      = 16;
  localparam int SeenW        = 3;
  localparam int HalfWidthDef = 2;
  // slot index width covers up to four results per word (half width of three)
  localparam int MaxHalfWidth = 3;
  localparam int SlotIdxW     = 2;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last_in;
  } in_word_t;

  typedef struct packed {
    sample_t filtered;
    logic    last_out;
  } out_word_t;

  // tells the output buffer which medians of a window to send
  typedef struct packed {
    logic [SlotIdxW-1:0] first_slot;
    logic [SlotIdxW-1:0] end_slot;
    logic                any;
    logic                flag;
  } ob_ctl_t;

endpackage

>>> src/sfm5_median.sv
`timescale 1ns / 1ps

module sfm5_median
  import sfm5_pkg::*;
#(
  parameter int WIN_LEN = 2 * HalfWidthDef + 1,
  localparam int IdxW = $clog2(WIN_LEN)
) (
  input  sample_t         win_i [WIN_LEN],
  input  logic [IdxW-1:0] lo_i,
  output sample_t         med_o
);

  logic [WIN_LEN-1:0] vld;
  logic [IdxW-1:0]    rank [WIN_LEN];
  logic [IdxW-1:0]    len;
  logic [IdxW-1:0]    target;

  // window runs from lo_i to the newest entry
  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      vld[i] = (IdxW'(i) >= lo_i);
    end
  end

  assign len    = IdxW'(WIN_LEN) - lo_i;
  assign target = len >> 1;

  // rank with ties broken by position, so ranks form a permutation
  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      rank[i] = '0;
      for (int m = 0; m < WIN_LEN; m++) begin
        if (m != i && vld[m] &&
            ((win_i[m] < win_i[i]) || (win_i[m] == win_i[i] && m < i))) begin
          rank[i] = rank[i] + IdxW'(1);
        end
      end
    end
  end

  always_comb begin
    med_o = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (vld[i] && rank[i] == target) begin
        med_o = win_i[i];
      end
    end
  end

endmodule

>>> src/sfm5_out_buf.sv
`timescale 1ns / 1ps

module sfm5_out_buf
  import sfm5_pkg::*;
#(
  parameter int NUM_SLOT = HalfWidthDef + 1,
  localparam int SlotW = (NUM_SLOT > 1) ? $clog2(NUM_SLOT) : 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  sample_t   med_i [NUM_SLOT],
  input  ob_ctl_t   ctl_i,
  output logic      load_rdy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  sample_t             med_q [NUM_SLOT];
  logic [SlotIdxW-1:0] cur_q, cur_d;
  logic [SlotIdxW-1:0] end_q, end_d;
  logic                busy_q, busy_d;
  logic                flag_q, flag_d;
  logic                pop;
  logic                fin;

  assign pop        = busy_q && !out_stall_i;
  assign fin        = pop && (cur_q == end_q);
  assign load_rdy_o = !busy_q || fin;

  assign out_valid_o         = busy_q;
  assign out_word_o.filtered = med_q[cur_q[SlotW-1:0]];
  assign out_word_o.last_out = flag_q && (cur_q == end_q);

  always_comb begin
    cur_d  = cur_q;
    end_d  = end_q;
    busy_d = busy_q;
    flag_d = flag_q;
    if (load_i) begin
      cur_d  = ctl_i.first_slot;
      end_d  = ctl_i.end_slot;
      busy_d = ctl_i.any;
      flag_d = ctl_i.flag;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (pop) begin
      cur_d = cur_q + SlotIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      end_q  <= '0;
      busy_q <= 1'b0;
      flag_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      end_q  <= end_d;
      busy_q <= busy_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      med_q <= med_i;
    end
  end

endmodule

>>> src/sliding_median5_filter.sv
`timescale 1ns / 1ps

// Sliding median over a block of signed 16-bit samples.
// Input channel: in_valid_i / in_stall_o with in_word_i (sample, last_in).
// Output channel: out_valid_o / out_stall_i with out_word_o (filtered, last_out).
// Each result is the median of the samples from two before to two after one
// position, clipped at the block edges; an even clipped length takes the upper
// middle value. Result i leaves once sample i+2 has been taken.
// A word with last_in set flushes up to HALF_WIDTH+1 results, the final one
// flagged with last_out, and the history starts over for the next block.
// A word passes the input register and then the output buffer before its result is offered.
// Throughput: one word per cycle while the output does not stall; a last word
// holds the output buffer until all its results have left, stalling the input.
// The median is chosen by one layer of pairwise compares and rank counts
// between the input register and the output buffer.
// While out_stall_i is high the offered word holds; if the input register is empty,
// one more input word is taken into it, then in_stall_o rises.
// Reset empties both stages and zeroes the sample count.

module sliding_median5_filter
  import sfm5_pkg::*;
#(
  parameter int HALF_WIDTH = HalfWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int HistDepth = 2 * HALF_WIDTH;
  localparam int WinLen    = HistDepth + 1;
  localparam int NumCtr    = HALF_WIDTH + 1;
  localparam int IdxW      = $clog2(WinLen);

  sample_t          hist_q [HistDepth];
  logic [SeenW-1:0] seen_q, seen_d;

  sample_t          s1_win_q [WinLen];
  logic [SeenW-1:0] s1_seen_q;
  logic             s1_last_q;
  logic             s1_valid_q, s1_valid_d;

  logic             in_acc;
  logic             load_rdy;
  logic             load;
  logic [IdxW-1:0]  first;
  sample_t          med [NumCtr];
  ob_ctl_t          ctl;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !load_rdy;
  assign load       = s1_valid_q && load_rdy;

  // history shifts on every word; after a last word the count alone restarts it
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < HistDepth - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HistDepth-1] <= in_word_i.sample;
      for (int i = 0; i < HistDepth; i++) begin
        s1_win_q[i] <= hist_q[i];
      end
      s1_win_q[HistDepth] <= in_word_i.sample;
      s1_seen_q           <= seen_q;
      s1_last_q           <= in_word_i.last_in;
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (in_acc) begin
      if (in_word_i.last_in) begin
        seen_d = '0;
      end else if (seen_q >= SeenW'(HistDepth)) begin
        seen_d = SeenW'(HistDepth);
      end else begin
        seen_d = seen_q + SeenW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // oldest window entry that belongs to this block
  assign first = IdxW'(HistDepth) - IdxW'(s1_seen_q);

  for (genvar j = 0; j < NumCtr; j++) begin : g_ctr
    logic [IdxW-1:0] lo;
    assign lo = (first > IdxW'(j)) ? first : IdxW'(j);

    sfm5_median #(
      .WIN_LEN(WinLen)
    ) u_median (
      .win_i(s1_win_q),
      .lo_i (lo),
      .med_o(med[j])
    );
  end

  always_comb begin
    if (s1_last_q) begin
      ctl.first_slot = (first > IdxW'(HALF_WIDTH)) ?
                       SlotIdxW'(first - IdxW'(HALF_WIDTH)) : '0;
      ctl.end_slot   = SlotIdxW'(HALF_WIDTH);
      ctl.any        = 1'b1;
      ctl.flag       = 1'b1;
    end else begin
      ctl.first_slot = '0;
      ctl.end_slot   = '0;
      ctl.any        = (s1_seen_q >= SeenW'(HALF_WIDTH));
      ctl.flag       = 1'b0;
    end
  end

  sfm5_out_buf #(
    .NUM_SLOT(NumCtr)
  ) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .med_i      (med),
    .ctl_i      (ctl),
    .load_rdy_o (load_rdy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenW'(HistDepth))
    else $error("sample count above history depth");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.last_in) |=> (seen_q == '0))
    else $error("count not cleared after last word");

  a_flush_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && s1_last_q) |=> out_valid_o)
    else $error("last word produced no result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && s1_valid_q))
    else $error("input stalled without a pending result");

endmodule
